FILE: src/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; used by every module of the block.
package hsv_pkg;

  localparam int PctW = 7;
  localparam int HueW = 9;
  localparam int ChanW = 8;
  localparam int LevelW = 15;      // 255 * value, at most 25500
  localparam int WeightW = 13;     // channel weight in 1/6000 steps, at most 6000
  localparam int ProdW = LevelW + WeightW;
  localparam int RecipShift = 40;
  localparam int RecipW = 21;
  localparam int DenomW = 20;

  localparam logic [PctW-1:0] PctMax = 7'd100;
  localparam logic [HueW-1:0] HueStep = 9'd60;
  localparam logic [LevelW-1:0] LevelScale = 15'd255;
  localparam logic [WeightW-1:0] WeightTop = 13'd6000;
  localparam logic [WeightW-1:0] WeightPct = 13'd60;
  localparam logic [DenomW-1:0] Denom = 20'd600000;
  localparam logic [RecipW-1:0] RecipMul = RecipW'((64'd1 << RecipShift) / 64'd600000);

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] saturation;
    logic [PctW-1:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } out_item_t;

  // Classified item: common level and one weight per channel.
  typedef struct packed {
    logic [LevelW-1:0]  level;
    logic [WeightW-1:0] wr;
    logic [WeightW-1:0] wg;
    logic [WeightW-1:0] wb;
  } work_t;

endpackage

FILE: src/hsv_to_rgb_converter_core.sv
// HSV to RGB converter: takes one item per clock, sustained while the result
// side keeps popping, and returns one truncated 8-bit colour per item in
// order. A colour shows on the result ports once its item has passed the
// front register (loaded at the accepting edge), the two-entry classify
// queue, the three-stage scale and divide pipeline of the back end (level
// multiply, reciprocal multiply, correction) and the write into the output
// queue. Two-entry queues on the middle and the output let either side stall
// without losing the one-per-clock rate. Depends on hsv_pkg.
module hsv_to_rgb_converter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  hsv_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output hsv_pkg::out_item_t result
);
  import hsv_pkg::*;

  work_t  f_data;
  work_t  m_data;
  logic   f_push;
  logic   m_full;
  logic   m_valid;
  logic   m_pop;

  hsv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (m_full),
    .q_push (f_push),
    .q_data (f_data)
  );

  hsv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_data),
    .full  (m_full),
    .pop   (m_pop),
    .valid (m_valid),
    .rdata (m_data)
  );

  hsv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (m_valid),
    .q_data  (m_data),
    .q_pop   (m_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

FILE: src/hsv_front.sv
// Front end: accepts an HSV item, clamps it, finds the hue sector and
// builds the per-channel weights. Depends on hsv_pkg.
module hsv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hsv_pkg::in_item_t item,
  input  logic              q_full,
  output logic              q_push,
  output hsv_pkg::work_t    q_data
);
  import hsv_pkg::*;

  logic                f_valid;
  work_t               f_work;
  work_t               work_next;
  logic [PctW-1:0]     sat_c;
  logic [PctW-1:0]     val_c;
  logic [3:0]          quo;
  logic [2:0]          sector;
  logic [5:0]          rem;
  logic [WeightW-1:0]  ramp;
  logic [WeightW-1:0]  bottom;
  logic [WeightW-1:0]  rising;
  logic [WeightW-1:0]  falling;
  logic                take;
  logic                go;

  always_comb begin
    sat_c = (item.saturation > PctMax) ? PctMax : item.saturation;
    val_c = (item.brightness > PctMax) ? PctMax : item.brightness;
    quo = '0;
    for (int k = 1; k <= 8; k++) begin
      if (item.hue >= HueW'(k * 60)) quo = quo + 4'd1;
    end
    rem = 6'(item.hue - HueW'(quo) * HueStep);
    // Hue past 359 folds into the last sector.
    sector = (quo > 4'd5) ? 3'd5 : quo[2:0];
    ramp = WeightW'(sat_c) * WeightW'(rem);
    bottom = WeightW'(PctMax - sat_c) * WeightPct;
    rising = bottom + ramp;
    falling = WeightTop - ramp;
    work_next.level = LevelW'(val_c) * LevelScale;
    unique case (sector)
      3'd0: begin
        work_next.wr = WeightTop; work_next.wg = rising;  work_next.wb = bottom;
      end
      3'd1: begin
        work_next.wr = falling;   work_next.wg = WeightTop; work_next.wb = bottom;
      end
      3'd2: begin
        work_next.wr = bottom;    work_next.wg = WeightTop; work_next.wb = rising;
      end
      3'd3: begin
        work_next.wr = bottom;    work_next.wg = falling; work_next.wb = WeightTop;
      end
      3'd4: begin
        work_next.wr = rising;    work_next.wg = bottom;  work_next.wb = WeightTop;
      end
      default: begin
        work_next.wr = WeightTop; work_next.wg = bottom;  work_next.wb = falling;
      end
    endcase
  end

  assign full   = rst || (f_valid && q_full);
  assign take   = push && !full;
  assign go     = f_valid && !q_full;
  assign q_push = go;
  assign q_data = f_work;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (go) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_work <= work_next;
    end
  end

endmodule

FILE: src/hsv_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on hsv_pkg.
module hsv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hsv_pkg::work_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output hsv_pkg::work_t rdata
);
  import hsv_pkg::*;

  work_t       mem [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        do_push;
  logic        do_pop;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

FILE: src/hsv_back.sv
// Back end: scales each weight by the level, divides by 600000 through a
// reciprocal multiply with one correction step, and queues the colour.
// Depends on hsv_pkg.
module hsv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  hsv_pkg::work_t     q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output hsv_pkg::out_item_t result
);
  import hsv_pkg::*;

  localparam int QuoW = 49;
  localparam int HiW = 29;

  logic                 v1, v2, v3;
  logic                 en1, en2, en3;
  logic [ProdW-1:0]     x1 [3];
  logic [ProdW-1:0]     x2 [3];
  logic [ChanW-1:0]     q2 [3];
  logic [ChanW-1:0]     c3 [3];
  logic [WeightW-1:0]   wt [3];
  logic [QuoW-1:0]      prod [3];
  logic [HiW-1:0]       hi [3];
  logic [ChanW-1:0]     fix [3];

  out_item_t            oq [2];
  logic                 owp;
  logic                 orp;
  logic [1:0]           ocnt;
  logic                 o_push;
  logic                 o_pop;

  assign wt[0] = q_data.wr;
  assign wt[1] = q_data.wg;
  assign wt[2] = q_data.wb;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = QuoW'(x1[c]) * QuoW'(RecipMul);
      // Reciprocal quotient may fall one short: bump it if x reaches the next step.
      hi[c] = HiW'({1'b0, q2[c]} + 9'd1) * HiW'(Denom);
      fix[c] = (HiW'(x2[c]) >= hi[c]) ? ChanW'(q2[c] + 8'd1) : q2[c];
    end
  end

  assign o_push = v3 && (ocnt != 2'd2);
  assign en3    = !v3 || o_push;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign q_pop  = q_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= q_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (en1) x1[c] <= ProdW'(q_data.level) * ProdW'(wt[c]);
      if (en2) begin
        x2[c] <= x1[c];
        q2[c] <= prod[c][RecipShift +: ChanW];
      end
      if (en3) c3[c] <= fix[c];
    end
  end

  // Output queue: hold the colour until it is popped.
  assign empty  = rst || (ocnt == 2'd0);
  assign o_pop  = pop && !empty;
  assign result = oq[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (o_push) owp <= !owp;
      if (o_pop) orp <= !orp;
      if (o_push && !o_pop) begin
        ocnt <= ocnt + 2'd1;
      end else if (o_pop && !o_push) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      oq[owp] <= '{red: c3[0], green: c3[1], blue: c3[2]};
    end
  end

endmodule

FILE: src/hsv_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv_pkg.
module hsv_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input hsv_pkg::in_item_t  item,
  input logic               empty,
  input logic               pop,
  input hsv_pkg::out_item_t result
);

  // Nothing may come out right after reset: reset empties the output queue.
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_empty_two_after_rst: assert property (@(posedge clk) $past(rst) |=> empty)
    else $error("result shown two cycles after reset");

  // Full only rises on a beat that was taken.
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted beat");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind hsv_to_rgb_converter_core hsv_checker u_hsv_checker (.*);
